>>> sv/assert_macros.svh
// Assertion macros shared by the keyed stream word decryptor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define KSWD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a rising clock edge outside reset.
`define KSWD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> sv/kswd_pkg.sv
// Constants, mix function and constant key table of the keyed stream word decryptor.
`default_nettype none

package kswd_pkg;

  localparam int KEY_TABLE_DEPTH = 256;
  localparam int KT_IDX_W        = $clog2(KEY_TABLE_DEPTH);

  localparam logic [31:0] SEED_A     = 32'h6A09E667;
  localparam logic [31:0] SEED_B     = 32'hBB67AE85;
  localparam logic [31:0] SEED_C     = 32'h3C6EF372;
  localparam logic [31:0] FMIX_M1    = 32'h85EBCA6B;
  localparam logic [31:0] FMIX_M2    = 32'hC2B2AE35;
  localparam logic [15:0] INDEX_MULT = 16'h1337;

  // Only the low half of each table entry reaches a character.
  typedef logic [15:0] key_table_t [KEY_TABLE_DEPTH];

  // Finalizer mix, evaluated only on constants at elaboration.
  function automatic logic [31:0] fmix32(input logic [31:0] x);
    logic [31:0] v;
    v = x;
    v = v ^ (v >> 16);
    v = v * FMIX_M1;
    v = v ^ (v >> 13);
    v = v * FMIX_M2;
    v = v ^ (v >> 16);
    return v;
  endfunction

  // Mixed constants: the base pad and the seed that the string key is folded into.
  localparam logic [31:0] BASE_MIX = fmix32(SEED_A);
  localparam logic [31:0] SEED_MIX = fmix32(SEED_A) ^ fmix32(SEED_B) ^ fmix32(SEED_C);

  // Key table: a chained mix of the constants, one entry per step.
  function automatic key_table_t build_key_table();
    key_table_t  t;
    logic [31:0] acc;
    logic [31:0] salt;
    acc  = fmix32(SEED_A) ^ fmix32(SEED_B);
    salt = fmix32(SEED_C);
    for (int n = 0; n < KEY_TABLE_DEPTH; n++) begin
      acc  = fmix32(acc ^ 32'(n) ^ salt);
      t[n] = acc[15:0];
    end
    return t;
  endfunction

  localparam key_table_t KEY_TABLE = build_key_table();

endpackage

`default_nettype wire

>>> sv/kswd_mix_unit.sv
// Two-pass finalizer mix around one shared 32x32 multiplier.
`default_nettype none

module kswd_mix_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] seed,
  output logic             done,
  output logic [31:0]      result
);

  logic        busy_r;
  logic        phase_r;
  logic [31:0] v_r;
  logic [31:0] mix_in;
  logic [31:0] mult_b;
  logic [31:0] prod_lo;

  // Shift-xor ahead of the multiplier and the constant for this pass.
  always_comb begin
    mix_in  = phase_r ? (v_r ^ (v_r >> 13)) : (v_r ^ (v_r >> 16));
    mult_b  = phase_r ? kswd_pkg::FMIX_M2 : kswd_pkg::FMIX_M1;
    prod_lo = mix_in * mult_b;
  end

  // The second pass ends the mix with the final shift-xor.
  assign done   = busy_r & phase_r;
  assign result = prod_lo ^ (prod_lo >> 16);

  // Pass sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
    end else if (start) begin
      busy_r  <= 1'b1;
      phase_r <= 1'b0;
    end else if (busy_r) begin
      busy_r  <= ~phase_r;
      phase_r <= ~phase_r;
    end
  end

  // Working value of the mix.
  always_ff @(posedge clk) begin
    if (start) begin
      v_r <= seed;
    end else if (busy_r && !phase_r) begin
      v_r <= prod_lo;
    end
  end

endmodule

`default_nettype wire

>>> sv/keyed_stream_word_decryptor.sv
// Top level of the keyed stream word decryptor.
`default_nettype none
`include "assert_macros.svh"

// Decrypts one 32-bit ciphertext word into one 16-bit character per word.
// A word that continues a string goes from the accept state to a decrypt
// state that needs only XORs against the running key, the index
// product and a constant key table. The first word of a string is held in
// the mix state, since the reseed key passes twice through the single shared
// 32x32 multiplier of the mix unit before the decrypt cycle. The result
// sits in an output register, so a new word is taken while the previous
// character still waits; the decrypt cycle holds only when that register
// is full and not being drained. The key table is constant logic built at
// elaboration, so the block is ready right after reset with no fill pass.
module keyed_stream_word_decryptor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_cipher_word,
  input  wire logic [31:0] in_string_key,
  input  wire logic        in_first_word,
  input  wire logic        in_last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_plain_char,
  output logic             out_last_char
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_DEC  = 2'd2;

  logic [1:0]                   state_r;
  logic [31:0]                  running_key_r;
  logic [kswd_pkg::KT_IDX_W-1:0] idx_r;
  logic [15:0]                  idx_prod_r;
  logic [31:0]                  word_r;
  logic                         last_r;
  logic                         out_valid_r;
  logic [15:0]                  out_char_r;
  logic                         out_last_r;

  logic        accept;
  logic        mix_start;
  logic        mix_done;
  logic [31:0] mix_result;
  logic        can_load;
  logic [15:0] char_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign mix_start = accept & in_first_word;
  assign can_load  = ~out_valid_r | out_ready;

  assign out_valid      = out_valid_r;
  assign out_plain_char = out_char_r;
  assign out_last_char  = out_last_r;

  // Reseed mix of the string key.
  kswd_mix_unit u_mix (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mix_start),
    .seed   (in_string_key ^ kswd_pkg::SEED_MIX),
    .done   (mix_done),
    .result (mix_result)
  );

  // Character pad: running key, index product, table entry and base constant.
  assign char_nxt = word_r[15:0] ^ running_key_r[15:0] ^ idx_prod_r
                  ^ kswd_pkg::KEY_TABLE[idx_r] ^ kswd_pkg::BASE_MIX[15:0];

  // Sequencer, key state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      running_key_r <= '0;
      idx_r         <= '0;
      idx_prod_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // A character loaded in this cycle wins over a drain of the old one.
      if (state_r == ST_DEC && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= in_first_word ? ST_MIX : ST_DEC;
          end
        end
        ST_MIX: begin
          if (mix_done) begin
            running_key_r <= mix_result;
            idx_r         <= '0;
            idx_prod_r    <= '0;
            state_r       <= ST_DEC;
          end
        end
        ST_DEC: begin
          if (can_load) begin
            running_key_r <= {running_key_r[24:0], running_key_r[31:25]} ^ word_r;
            idx_r         <= idx_r + 1'b1;
            idx_prod_r    <= idx_prod_r + kswd_pkg::INDEX_MULT;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Captured word and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_cipher_word;
      last_r <= in_last_word;
    end
    if (state_r == ST_DEC && can_load) begin
      out_char_r <= char_nxt;
      out_last_r <= last_r;
    end
  end

  `KSWD_ASSERT(a_first_word_mixes, clk, rst_n, (accept && in_first_word) |=> (state_r == ST_MIX), "first word did not start the reseed mix")
  `KSWD_ASSERT(a_mix_done_in_mix, clk, rst_n, mix_done |-> (state_r == ST_MIX), "mix finished outside the mix state")
  `KSWD_ASSERT(a_decrypt_loads, clk, rst_n, (state_r == ST_DEC && can_load) |=> (out_valid_r && state_r == ST_IDLE), "decrypt cycle did not load a character")
  `KSWD_ASSERT_NEVER(a_no_accept_in_mix, clk, rst_n, mix_done && in_ready, "word taken while the reseed mix runs")

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the keyed stream word decryptor.
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_WORDS  = 1130;
  localparam int LONG_HOLD     = 300;
  localparam int PRESSURE_LEN  = 60;
  localparam int SETTLE_CYCLES = 20;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [31:0] SEED_A     = 32'h6A09E667;
  localparam logic [31:0] SEED_B     = 32'hBB67AE85;
  localparam logic [31:0] SEED_C     = 32'h3C6EF372;
  localparam logic [31:0] MIX_MUL1   = 32'h85EBCA6B;
  localparam logic [31:0] MIX_MUL2   = 32'hC2B2AE35;
  localparam logic [31:0] INDEX_STEP = 32'h00001337;

  // One word offered to the block.
  typedef struct packed {
    logic [31:0] word;
    logic [31:0] skey;
    logic        first;
    logic        last;
  } word_item_t;

  // One character expected back.
  typedef struct packed {
    logic [15:0] plain_char;
    logic        last_char;
  } char_result_t;

  // Finalizer mix used for the key schedule.
  function automatic logic [31:0] murmur_final(input logic [31:0] x);
    logic [31:0] v;
    v = x;
    v = v ^ (v >> 16);
    v = v * MIX_MUL1;
    v = v ^ (v >> 13);
    v = v * MIX_MUL2;
    v = v ^ (v >> 16);
    return v;
  endfunction

  localparam logic [31:0] BASE_MIX = murmur_final(SEED_A);
  localparam logic [31:0] SEED_MIX =
    murmur_final(SEED_A) ^ murmur_final(SEED_B) ^ murmur_final(SEED_C);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_cipher_word = '0;
  logic [31:0] in_string_key = '0;
  logic        in_first_word = 1'b0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_plain_char;
  logic        out_last_char;

  // Predictor state and bookkeeping.
  logic [31:0]  pad_table [256];
  logic [31:0]  run_key = '0;
  logic [15:0]  char_idx = '0;
  char_result_t expected_chars [$];
  logic         quiet = 1'b0;
  int           holds_asked = 0;
  int           mismatch_count = 0;
  int           words_sent = 0;
  int           chars_checked = 0;
  int           strings_sent = 0;
  int           longest_string = 0;
  int           cycle_count = 0;

  keyed_stream_word_decryptor dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cipher_word (in_cipher_word),
    .in_string_key  (in_string_key),
    .in_first_word  (in_first_word),
    .in_last_word   (in_last_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_plain_char (out_plain_char),
    .out_last_char  (out_last_char)
  );

  always #2 clk = ~clk;

  // Directed words. Every character hangs on mixed constants, so none can be
  // read off by eye; all rows go through the predictor.
  localparam int DIRECTED_COUNT = 18;
  word_item_t directed_words [DIRECTED_COUNT] = '{
    // Words before any first word run on the reset key and index.
    '{32'h00000000, 32'hFFFFFFFF, 1'b0, 1'b0},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0},
    '{32'hFFFFFFFF, 32'h00000000, 1'b0, 1'b1},
    // A string keyed with all zeros; keys on later words are ignored.
    '{32'h00000000, 32'h00000000, 1'b1, 1'b0},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0},
    '{32'h0000FFFF, 32'h00000000, 1'b0, 1'b0},
    '{32'hFFFF0000, 32'h00000000, 1'b0, 1'b1},
    // One-word strings, first and last at once.
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1},
    '{32'h00000000, 32'h00000000, 1'b1, 1'b1},
    // A string keyed with all ones.
    '{32'h80000000, 32'hFFFFFFFF, 1'b1, 1'b0},
    '{32'h00000001, 32'h00000000, 1'b0, 1'b0},
    '{32'hA5A5A5A5, 32'h5A5A5A5A, 1'b0, 1'b0},
    '{32'h5A5A5A5A, 32'h00000000, 1'b0, 1'b1},
    // A word after the last one keeps running on the old key.
    '{32'h12345678, 32'h00000000, 1'b0, 1'b0},
    // Two first words in a row: the second reseeds again.
    '{32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b0},
    '{32'h00000001, 32'h00000001, 1'b1, 1'b0},
    '{32'h13579BDF, 32'h00000000, 1'b0, 1'b1},
    '{32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b1}
  };

  // Decrypts one word and advances the running key and index.
  function automatic logic [15:0] decrypt_word(input logic [31:0] word,
                                               input logic [31:0] skey,
                                               input logic        first);
    logic [31:0] pad;
    if (first) begin
      run_key  = murmur_final(SEED_MIX ^ skey);
      char_idx = '0;
    end
    pad = run_key ^ (32'(char_idx) * INDEX_STEP) ^ pad_table[char_idx[7:0]] ^ BASE_MIX;
    run_key  = {run_key[24:0], run_key[31:25]} ^ word;
    char_idx = char_idx + 16'd1;
    return word[15:0] ^ pad[15:0];
  endfunction

  // Length of an idle gap or a stall: mostly short, a few long.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("testbench: mismatch on %s: expected %h, got %h", what, want, got);
  endfunction

  // Offers one word, waits for it to be taken, then records its character.
  task automatic send_word(input word_item_t w);
    char_result_t want;
    in_valid       <= 1'b1;
    in_cipher_word <= w.word;
    in_string_key  <= w.skey;
    in_first_word  <= w.first;
    in_last_word   <= w.last;
    do @(posedge clk); while (!in_ready);
    want.plain_char = decrypt_word(w.word, w.skey, w.first);
    want.last_char  = w.last;
    expected_chars.push_back(want);
    words_sent++;
    if (!quiet && $urandom_range(0, 99) < 40) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // A well-formed string: first word keyed, last word flagged.
  task automatic send_string(input int len);
    word_item_t w;
    for (int n = 0; n < len; n++) begin
      w.word  = $urandom;
      w.skey  = $urandom;
      w.first = (n == 0);
      w.last  = (n == len - 1);
      send_word(w);
    end
    strings_sent++;
    if (len > longest_string) longest_string = len;
  endtask

  // Stops offering words until every character has come back.
  task automatic drain_chars();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  // Result side: checks each taken character and drives out_ready.
  initial begin : char_side
    int   stall_left;
    int   holds_done;
    logic ready_next;
    char_result_t want;
    stall_left = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          note_mismatch("character with none expected", 32'h0, {15'h0, out_last_char,
                        out_plain_char});
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (out_plain_char !== want.plain_char)
            note_mismatch("plain_char", 32'(want.plain_char), 32'(out_plain_char));
          if (out_last_char !== want.last_char)
            note_mismatch("last_char", 32'(want.last_char), 32'(out_last_char));
        end
      end
      // A requested long hold overrides the random stalls.
      if (holds_done != holds_asked) begin
        holds_done++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap() - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready <= ready_next;
    end
  end

  // Run limit.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // Stimulus.
  initial begin : word_side
    logic [31:0] acc;
    logic [31:0] salt;
    int          r;
    word_item_t  w;
    bit          pressured;
    bit          paused;
    bit          calm;

    // Constant key table, chained from the seeds.
    acc  = murmur_final(SEED_A) ^ murmur_final(SEED_B);
    salt = murmur_final(SEED_C);
    for (int n = 0; n < 256; n++) begin
      acc = murmur_final(acc ^ 32'(n) ^ salt);
      pad_table[n] = acc;
    end
    pressured = 1'b0;
    paused    = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words, then a pause until the block is empty.
    for (int n = 0; n < DIRECTED_COUNT; n++) send_word(directed_words[n]);
    drain_chars();

    // Random part: mostly well-formed strings, some stray words.
    while (words_sent < DIRECTED_COUNT + RANDOM_WORDS) begin
      // The pressure string is always sent without gaps.
      calm = ($urandom_range(0, 5) == 0) || (!pressured && words_sent > 300);
      quiet <= calm;
      if (!pressured && words_sent > 300) begin
        // Hold the result side for a long stretch while words keep coming.
        pressured = 1'b1;
        holds_asked <= holds_asked + 1;
        send_string(PRESSURE_LEN);
      end else if (!paused && words_sent > 700) begin
        paused = 1'b1;
        drain_chars();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          send_string($urandom_range(1, 12));
        end else if (r < 82) begin
          send_string($urandom_range(13, 64));
        end else if (r < 85) begin
          // Crosses the wrap of the table index.
          send_string($urandom_range(257, 300));
        end else begin
          repeat ($urandom_range(1, 4)) begin
            w.word  = $urandom;
            w.skey  = $urandom;
            w.first = ($urandom_range(0, 3) == 0);
            w.last  = ($urandom_range(0, 3) == 0);
            send_word(w);
          end
        end
      end
    end

    drain_chars();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("testbench: %0d words sent, %0d characters checked, %0d mismatches",
             words_sent, chars_checked, mismatch_count);
    $display("testbench: %0d strings, longest %0d words, long output hold done",
             strings_sent, longest_string);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
